>>> sv/assert_macros.svh
// Assertion macros shared by the blit unit modules.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/fbsr_pkg.sv
// Package for the blit unit: configuration struct, register indexes, defaults.
// No dependencies.
`timescale 1ns / 1ps
package fbsr_pkg;

	localparam int DEF_MAX_DIM   = 1024;
	localparam int DEF_ADDR_BITS = 22;
	localparam int QUEUE_DEPTH   = 4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;
	localparam int PIXEL_W    = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_LOG2   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_SIZE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATE       = 3'd4;

	localparam logic [10:0] RST_FRAME_WIDTH  = 11'd320;
	localparam logic [10:0] RST_FRAME_HEIGHT = 11'd480;
	localparam logic [3:0]  RST_PITCH_LOG2   = 4'd9;

	typedef struct packed {
		logic [10:0] frame_width;
		logic [10:0] frame_height;
		logic [3:0]  pitch_log2;
		logic        double_size;
		logic        rotate_half_turn;
	} cfg_t;

endpackage

>>> sv/fbsr_front.sv
// Front end of the blit unit: accepts pixels, tracks position, forms base address.
// Depends on fbsr_pkg.
`timescale 1ns / 1ps
module fbsr_front import fbsr_pkg::*; #(
	parameter int MAX_DIM   = DEF_MAX_DIM,
	parameter int ADDR_BITS = DEF_ADDR_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [PIXEL_W-1:0]         s_pixel,
	output logic                       push,
	output logic [ADDR_BITS+PIXEL_W:0] push_data,
	input  logic                       full
);

	localparam int CW   = $clog2(MAX_DIM);
	localparam int CMPW = (CW + 1 > 11) ? CW + 1 : 11;
	localparam logic [CMPW-1:0] MAX_C = CMPW'(MAX_DIM);
	localparam logic [CMPW-1:0] ONE_C = CMPW'(1);

	logic [CW-1:0]      col_q, row_q;
	logic [CMPW-1:0]    fw, fh, w, h;
	logic [CW-1:0]      wm1, hm1;
	logic [CW:0]        row_inc;
	logic [CW-1:0]      col_eff, row_eff;
	logic               accept, adv, done;

	logic               valid_s1;
	logic [CW-1:0]      col_s1, row_s1;
	logic [PIXEL_W-1:0] pix_s1;
	logic               done_s1;
	logic [4:0]         shift;
	logic [ADDR_BITS-1:0] base;

	assign fw  = CMPW'(cfg.frame_width);
	assign fh  = CMPW'(cfg.frame_height);
	assign w   = (fw == '0) ? ONE_C : ((fw > MAX_C) ? MAX_C : fw);
	assign h   = (fh == '0) ? ONE_C : ((fh > MAX_C) ? MAX_C : fh);
	assign wm1 = CW'(w - ONE_C);
	assign hm1 = CW'(h - ONE_C);

	assign adv      = valid_s1 && !full;
	assign s_tready = !valid_s1 || !full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		row_inc = {1'b0, row_q} + {{CW{1'b0}}, (col_q > wm1)};
		col_eff = (col_q > wm1) ? '0 : col_q;
		row_eff = (row_inc > {1'b0, hm1}) ? '0 : row_inc[CW-1:0];
		done    = (col_eff == wm1) && (row_eff == hm1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_eff == wm1) begin
				col_q <= '0;
				row_q <= (row_eff == hm1) ? '0 : row_eff + CW'(1);
			end else begin
				col_q <= col_eff + CW'(1);
				row_q <= row_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1  <= cfg.rotate_half_turn ? wm1 - col_eff : col_eff;
			row_s1  <= cfg.rotate_half_turn ? hm1 - row_eff : row_eff;
			pix_s1  <= s_pixel;
			done_s1 <= done;
		end
	end

	assign shift = {1'b0, cfg.pitch_log2} + {4'd0, cfg.double_size};
	assign base  = (ADDR_BITS'(row_s1) << shift)
		+ (ADDR_BITS'(col_s1) << cfg.double_size);

	assign push      = adv;
	assign push_data = {done_s1, pix_s1, base};

endmodule

>>> sv/fbsr_queue.sv
// Short register queue between the front and back ends of the blit unit.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fbsr_queue #(
	parameter int WIDTH = 39,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             valid
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]    count_q;

	assign full  = (count_q == NW'(DEPTH));
	assign valid = (count_q != '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	`ASSERT_IMPLIES(a_no_push_full, clk, arst_n, push, !full)
	`ASSERT_IMPLIES(a_no_pop_empty, clk, arst_n, pop, valid)
	`ASSERT_NEXT(a_push_fills, clk, arst_n, push && !pop, valid)

endmodule

>>> sv/fbsr_back.sv
// Back end of the blit unit: expands each queued request into one or four writes.
// Depends on fbsr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fbsr_back import fbsr_pkg::*; #(
	parameter int ADDR_BITS = DEF_ADDR_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       q_valid,
	input  logic [ADDR_BITS+PIXEL_W:0] q_data,
	output logic                       pop,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [ADDR_BITS-1:0]       m_address,
	output logic [PIXEL_W-1:0]         m_pixel,
	output logic                       m_tlast,
	output logic                       m_tuser
);

	logic [1:0]           beat_q;
	logic                 out_valid_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [PIXEL_W-1:0]   pix_q;
	logic                 last_q, done_q;

	logic [ADDR_BITS-1:0] base, pitch, offs;
	logic                 load, last;

	assign base  = q_data[ADDR_BITS-1:0];
	assign pitch = ADDR_BITS'(1) << cfg.pitch_log2;

	always_comb begin
		case (beat_q)
			2'd0:    offs = '0;
			2'd1:    offs = ADDR_BITS'(1);
			2'd2:    offs = pitch;
			default: offs = pitch + ADDR_BITS'(1);
		endcase
	end

	assign load = q_valid && (!out_valid_q || m_tready);
	assign last = !cfg.double_size || (beat_q == 2'd3);
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				beat_q <= last ? 2'd0 : beat_q + 2'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			addr_q <= base + offs;
			pix_q  <= q_data[ADDR_BITS+PIXEL_W-1:ADDR_BITS];
			last_q <= last;
			done_q <= q_data[ADDR_BITS+PIXEL_W];
		end
	end

	assign m_tvalid  = out_valid_q;
	assign m_address = addr_q;
	assign m_pixel   = pix_q;
	assign m_tlast   = last_q;
	assign m_tuser   = done_q;

	`ASSERT_IMPLIES(a_beat_needs_double, clk, arst_n, beat_q != 2'd0, cfg.double_size)
	`ASSERT_IMPLIES(a_beat_holds_entry, clk, arst_n, beat_q != 2'd0, q_valid)
	`ASSERT_IMPLIES(a_pop_on_last, clk, arst_n, pop, load && last)
	`ASSERT_NEXT(a_load_shows, clk, arst_n, load, m_tvalid)

endmodule

>>> sv/frame_blit_scale_rotate_unit.sv
// Blit unit with 2x scaling and half-turn rotation: top level, configuration registers.
// Depends on fbsr_pkg, fbsr_front, fbsr_queue and fbsr_back.
//
// Takes RGB565 source pixels in row-major order and emits surface writes (address,
// pixel), one write per cycle while m_tready is set: normal mode sustains one pixel per
// cycle, double-size mode one pixel per four writes, set by the back end's beat counter
// that walks the 2x2 block. A pixel passes the front stage register, a four-entry queue
// that parts the position tracking front end from the write back end, and the output
// register. The user must write configuration only while idle; it is not enforced.
`timescale 1ns / 1ps
module frame_blit_scale_rotate_unit import fbsr_pkg::*; #(
	parameter int MAX_DIM   = DEF_MAX_DIM,
	parameter int ADDR_BITS = DEF_ADDR_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [PIXEL_W-1:0]    s_tdata,   // src_pixel
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// dest_address, dest_pixel, zero fill
	output logic [((ADDR_BITS+PIXEL_W+7)/8)*8-1:0] m_tdata,
	output logic                  m_tlast,   // last_of_run
	output logic                  m_tuser    // frame_done
);

	localparam int EW   = ADDR_BITS + PIXEL_W + 1;
	localparam int TDW  = ((ADDR_BITS + PIXEL_W + 7) / 8) * 8;
	localparam int FILL = TDW - ADDR_BITS - PIXEL_W;

	cfg_t                 cfg_q;
	logic                 push, full, pop, q_valid;
	logic [EW-1:0]        push_data, q_data;
	logic [ADDR_BITS-1:0] m_address;
	logic [PIXEL_W-1:0]   m_pixel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width      <= RST_FRAME_WIDTH;
			cfg_q.frame_height     <= RST_FRAME_HEIGHT;
			cfg_q.pitch_log2       <= RST_PITCH_LOG2;
			cfg_q.double_size      <= 1'b0;
			cfg_q.rotate_half_turn <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  cfg_q.frame_width      <= cfg_wdata;
				REG_FRAME_HEIGHT: cfg_q.frame_height     <= cfg_wdata;
				REG_PITCH_LOG2:   cfg_q.pitch_log2       <= cfg_wdata[3:0];
				REG_DOUBLE_SIZE:  cfg_q.double_size      <= cfg_wdata[0];
				REG_ROTATE:       cfg_q.rotate_half_turn <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	fbsr_front #(
		.MAX_DIM   (MAX_DIM),
		.ADDR_BITS (ADDR_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_pixel   (s_tdata),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	fbsr_queue #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.full   (full),
		.pop    (pop),
		.rdata  (q_data),
		.valid  (q_valid)
	);

	fbsr_back #(
		.ADDR_BITS (ADDR_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_address (m_address),
		.m_pixel   (m_pixel),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	assign m_tdata = {{FILL{1'b0}}, m_pixel, m_address};

endmodule

>>> tb/frame_blit_scale_rotate_unit_tb.sv
// Testbench for frame_blit_scale_rotate_unit: pixel requests in, checked surface writes out.
// Predicts each write from its own column/row tracking and register shadow.
// Depends on fbsr_pkg and the unit's RTL.
`timescale 1ns / 1ps
module frame_blit_scale_rotate_unit_tb;
	import fbsr_pkg::*;

	localparam int TDATA_W      = ((DEF_ADDR_BITS + PIXEL_W + 7) / 8) * 8;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [DEF_ADDR_BITS-1:0] addr;
		logic [PIXEL_W-1:0]       pixel;
		logic                     run_end;
		logic                     frame_end;
	} surface_write_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [PIXEL_W-1:0]    s_tdata   = '0;   // src_pixel
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [TDATA_W-1:0]    m_tdata;          // dest_address, dest_pixel, zero fill
	logic                  m_tlast;          // last_of_run
	logic                  m_tuser;          // frame_done

	cfg_t           cur_cfg;
	int             col_pos;
	int             row_pos;
	surface_write_t pending_writes[$];
	int             failures    = 0;
	int             gap_pct     = 0;
	int             stall_pct   = 0;
	int             stall_left  = 0;
	int             idle_cycles = 0;

	always #5 clk = ~clk;

	frame_blit_scale_rotate_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	function automatic int pick_gap(input int pct);
		int n;
		n = 0;
		if ($urandom_range(0, 99) < pct)
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
		return n;
	endfunction

	function automatic int eff_dim(input logic [10:0] v);
		if (v == 0)
			return 1;
		if (v > DEF_MAX_DIM)
			return DEF_MAX_DIM;
		return int'(v);
	endfunction

	function automatic logic [10:0] pick_dim();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			return 11'd0;
		if (sel == 1)
			return 11'($urandom_range(DEF_MAX_DIM + 1, 2047));
		if (sel == 2)
			return 11'(DEF_MAX_DIM);
		return 11'($urandom_range(1, 8));
	endfunction

	task automatic predict_writes(input logic [PIXEL_W-1:0] px);
		int w;
		int h;
		longint unsigned col;
		longint unsigned row;
		longint unsigned pitch;
		longint unsigned base;
		longint unsigned a;
		surface_write_t wr;
		w = eff_dim(cur_cfg.frame_width);
		h = eff_dim(cur_cfg.frame_height);
		pitch = 64'd1 << cur_cfg.pitch_log2;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h)
			row_pos = 0;
		wr.pixel = px;
		wr.frame_end = (col_pos == w - 1) && (row_pos == h - 1);
		col = col_pos;
		row = row_pos;
		if (cur_cfg.rotate_half_turn) begin
			col = w - 1 - col_pos;
			row = h - 1 - row_pos;
		end
		if (cur_cfg.double_size) begin
			base = 2 * row * pitch + 2 * col;
			for (int k = 0; k < 4; k++) begin
				a = base + ((k >= 2) ? pitch : 64'd0) + (k % 2);
				wr.addr = a[DEF_ADDR_BITS-1:0];
				wr.run_end = (k == 3);
				pending_writes.push_back(wr);
			end
		end else begin
			a = row * pitch + col;
			wr.addr = a[DEF_ADDR_BITS-1:0];
			wr.run_end = 1'b1;
			pending_writes.push_back(wr);
		end
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h)
				row_pos = 0;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_FRAME_WIDTH: cur_cfg.frame_width = val;
			REG_FRAME_HEIGHT: cur_cfg.frame_height = val;
			REG_PITCH_LOG2: cur_cfg.pitch_log2 = val[3:0];
			REG_DOUBLE_SIZE: cur_cfg.double_size = val[0];
			REG_ROTATE: cur_cfg.rotate_half_turn = val[0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [10:0] w, input logic [10:0] h, input logic [3:0] p,
			input logic dbl, input logic rot);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_PITCH_LOG2, CFG_DATA_W'(p));
		write_reg(REG_DOUBLE_SIZE, CFG_DATA_W'(dbl));
		write_reg(REG_ROTATE, CFG_DATA_W'(rot));
		cfg_we <= 1'b0;
	endtask

	task automatic send_pixel(input logic [PIXEL_W-1:0] px);
		int gap;
		gap = pick_gap(gap_pct);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_writes(px);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_reset_defaults();
		gap_pct = 30;
		stall_pct = 30;
		send_pixel(16'h0000);
		send_pixel(16'hFFFF);
		send_pixel(16'h5A5A);
		drain();
	endtask

	// Counters sit beyond the new width: restart the column, advance the row.
	task automatic test_counter_past_size();
		configure(11'd2, 11'd2, 4'd0, 1'b1, 1'b1);
		send_pixel(16'h1234);
		send_pixel(16'hA5A5);
		send_pixel(16'hFFFF);
		drain();
	endtask

	task automatic test_zero_size();
		configure(11'd0, 11'd0, 4'd15, 1'b1, 1'b0);
		send_pixel(16'h8001);
		send_pixel(16'h7FFE);
		drain();
	endtask

	task automatic test_oversized_size();
		configure(11'h7FF, 11'h7FF, 4'd15, 1'b1, 1'b1);
		send_pixel(16'hFFFF);
		send_pixel(16'h0000);
		drain();
		configure(11'(DEF_MAX_DIM), 11'(DEF_MAX_DIM), 4'd12, 1'b0, 1'b1);
		send_pixel(16'hC3C3);
		drain();
	endtask

	task automatic test_unused_index();
		for (int i = int'(REG_ROTATE) + 1; i < (1 << CFG_IDX_W); i++)
			write_reg(CFG_IDX_W'(i), '1);
		configure(11'd3, 11'd2, 4'd11, 1'b0, 1'b0);
		repeat (6) send_pixel(16'($urandom_range(0, 65535)));
		drain();
	endtask

	// Row sits beyond the new height: restart it.
	task automatic test_row_past_height();
		configure(11'd4, 11'd4, 4'd3, 1'b0, 1'b1);
		repeat (5) send_pixel(16'($urandom_range(0, 65535)));
		drain();
		configure(11'd4, 11'd1, 4'd3, 1'b1, 1'b0);
		repeat (2) send_pixel(16'($urandom_range(0, 65535)));
		drain();
	endtask

	task automatic test_random_frames();
		int sent;
		int phase;
		int n;
		sent = 0;
		phase = 0;
		while (sent < 405) begin
			if (phase % 4 == 0) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				gap_pct = $urandom_range(5, 60);
				stall_pct = $urandom_range(5, 60);
			end
			configure(pick_dim(), pick_dim(), 4'($urandom_range(0, 15)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			n = $urandom_range(12, 36);
			repeat (n) send_pixel(16'($urandom_range(0, 65535)));
			sent += n;
			drain();
			phase++;
		end
	endtask

	always @(posedge clk) begin : sink
		surface_write_t exp_wr;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_writes.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected write: addr %h pixel %h last %b done %b",
						m_tdata[DEF_ADDR_BITS-1:0], m_tdata[DEF_ADDR_BITS +: PIXEL_W],
						m_tlast, m_tuser);
			end else begin
				exp_wr = pending_writes.pop_front();
				if (m_tdata[DEF_ADDR_BITS-1:0] !== exp_wr.addr
						|| m_tdata[DEF_ADDR_BITS +: PIXEL_W] !== exp_wr.pixel
						|| m_tdata[TDATA_W-1:DEF_ADDR_BITS+PIXEL_W] !== '0
						|| m_tlast !== exp_wr.run_end || m_tuser !== exp_wr.frame_end) begin
					failures++;
					if (failures <= 10) begin
						$display("write mismatch: exp addr %h pixel %h last %b done %b",
							exp_wr.addr, exp_wr.pixel, exp_wr.run_end, exp_wr.frame_end);
						$display("  got addr %h pixel %h last %b done %b fill %b",
							m_tdata[DEF_ADDR_BITS-1:0], m_tdata[DEF_ADDR_BITS +: PIXEL_W],
							m_tlast, m_tuser, m_tdata[TDATA_W-1:DEF_ADDR_BITS+PIXEL_W]);
					end
				end
			end
		end
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			stall_left = pick_gap(stall_pct);
			m_tready <= (stall_left == 0);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else if (arst_n) begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		cur_cfg.frame_width = RST_FRAME_WIDTH;
		cur_cfg.frame_height = RST_FRAME_HEIGHT;
		cur_cfg.pitch_log2 = RST_PITCH_LOG2;
		cur_cfg.double_size = 1'b0;
		cur_cfg.rotate_half_turn = 1'b0;
		col_pos = 0;
		row_pos = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_counter_past_size();
		test_zero_size();
		test_oversized_size();
		test_unused_index();
		test_row_past_height();
		test_random_frames();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && pending_writes.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> sim.f
+incdir+sv
sv/fbsr_pkg.sv
sv/fbsr_front.sv
sv/fbsr_queue.sv
sv/fbsr_back.sv
sv/frame_blit_scale_rotate_unit.sv
tb/frame_blit_scale_rotate_unit_tb.sv
